### hdl/i2af_pkg.sv
// i2af_pkg: shared types, ASCII constants and helper functions for the
// integer to ASCII formatter. No dependencies; used by i2af_conv and the
// top level integer_to_ascii_formatter.
package i2af_pkg;

	// default value width and bits folded into the BCD register per cycle
	localparam int VALUE_BITS_DEF = 32;
	localparam int STEP_BITS      = 8;

	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_MINUS   = 8'h2D;
	localparam logic [3:0] DEC_RADIX     = 4'd10;

	// format select carried on the input tuser
	typedef enum logic [1:0] {
		FUNC_SDEC = 2'd0,
		FUNC_UDEC = 2'd1,
		FUNC_HEXL = 2'd2,
		FUNC_HEXU = 2'd3
	} func_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// digit slots needed for the larger of the decimal and hex forms
	function automatic int num_digits(int bits);
		int dec;
		int hex;
		begin
			dec = (bits * 30103 + 99999) / 100000;
			hex = (bits + 3) / 4;
			return (dec > hex) ? dec : hex;
		end
	endfunction

	// one digit (0..15) to its ASCII character
	function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
		logic [7:0] base;
		begin
			base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
			if (d < DEC_RADIX)
				return ASCII_ZERO + {4'b0000, d};
			else
				return base + {4'b0000, d} - {4'b0000, DEC_RADIX};
		end
	endfunction

endpackage

### hdl/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level. Sequencer around i2af_conv that
// prints a value as signed/unsigned decimal or hex text, one character a beat.
// Depends on i2af_pkg and i2af_conv.
//
//  channel   dir  tdata                   tuser       tlast
//  s_axis    in   value[VALUE_BITS-1:0]   func[1:0]   -
//  m_axis    out  ascii_char[7:0]         -           last character
//
// Steps: accept, the digit unit (ceil(VALUE_BITS/8) double dabble steps for
// decimal, a direct load for hex), digit search, then one beat per character
// (up to 11 at 32 bits). s_axis_tready is high only while the sequencer is
// idle; the last character may still wait in the output register while the
// next beat enters. Output stalls hold the sequencer. arst_n clears the
// sequencer and tvalid.
module integer_to_ascii_formatter #(
	parameter int VALUE_BITS = i2af_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [VALUE_BITS-1:0] value
	input  logic [1:0]                          s_axis_tuser,  // [1:0] func
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata,  // [7:0] ascii_char
	output logic                                m_axis_tlast
);
	import i2af_pkg::*;

	localparam int NDIG  = num_digits(VALUE_BITS);
	localparam int IDX_W = $clog2(NDIG);

	state_t                  state_q, state_d;
	func_t                   func_q;
	func_t                   in_func;
	logic                    minus_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        find_idx;
	logic                    m_valid_q;
	logic [7:0]              m_data_q;
	logic                    m_last_q;
	logic [VALUE_BITS-1:0]   in_value;
	logic                    in_neg;
	logic [VALUE_BITS-1:0]   mag;
	logic                    accept;
	logic                    out_free;
	logic                    load_out;
	logic [7:0]              load_char;
	logic                    load_last;
	logic                    conv_done;
	logic [4*NDIG-1:0]       digits;
	logic [3:0]              cur_digit;

	// input decode: sign and magnitude
	assign in_func  = func_t'(s_axis_tuser);
	assign in_value = s_axis_tdata[VALUE_BITS-1:0];
	assign in_neg   = (in_func == FUNC_SDEC) && in_value[VALUE_BITS-1];
	assign mag      = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	i2af_conv #(
		.VALUE_BITS(VALUE_BITS)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.hex    (in_func == FUNC_HEXL || in_func == FUNC_HEXU),
		.mag    (mag),
		.done   (conv_done),
		.digits (digits)
	);

	// highest nonzero digit; zero value prints a single digit
	always_comb begin
		find_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (digits[4*i +: 4] != 4'd0)
				find_idx = IDX_W'(i);
		end
	end

	assign cur_digit = digits[{idx_q, 2'b00} +: 4];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_CONV;
			ST_CONV: if (conv_done) state_d = ST_FIND;
			ST_FIND: state_d = minus_q ? ST_SIGN : ST_EMIT;
			ST_SIGN: if (out_free) state_d = ST_EMIT;
			ST_EMIT: if (out_free && idx_q == '0) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		load_char     = ASCII_MINUS;
		load_last     = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_CONV, ST_FIND: ;
			ST_SIGN: load_out = out_free;
			ST_EMIT: begin
				load_out  = out_free;
				load_char = digit_char(cur_digit, func_q == FUNC_HEXU);
				load_last = (idx_q == '0);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_func;
			minus_q <= in_neg;
		end
		if (state_q == ST_FIND)
			idx_q <= find_idx;
		else if (state_q == ST_EMIT && load_out && idx_q != '0)
			idx_q <= idx_q - IDX_W'(1);
		if (load_out) begin
			m_data_q <= load_char;
			m_last_q <= load_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	// an accepted beat always starts a conversion
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV))
		else $error("accepted beat did not start conversion");

	// the digit unit only reports completion while the sequencer waits on it
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> (state_q == ST_CONV))
		else $error("conversion done outside CONV");

	// a minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata == ASCII_MINUS) |-> !m_axis_tlast)
		else $error("minus sign flagged as last");

	// decimal text only ever shows decimal digits
	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && (func_q == FUNC_SDEC || func_q == FUNC_UDEC))
			|-> (cur_digit < DEC_RADIX))
		else $error("non-decimal digit in decimal mode");

endmodule

### hdl/i2af_conv.sv
// i2af_conv: digit register for the formatter. Decimal values go through a
// shift-and-add-3 (double dabble) unit, STEP_BITS bits per cycle; hex values
// load straight in. Depends on i2af_pkg.
module i2af_conv #(
	parameter int VALUE_BITS = i2af_pkg::VALUE_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              start,
	input  logic                                              hex,
	input  logic [VALUE_BITS-1:0]                             mag,
	output logic                                              done,
	output logic [4*i2af_pkg::num_digits(VALUE_BITS)-1:0]     digits
);
	import i2af_pkg::*;

	localparam int NDIG  = num_digits(VALUE_BITS);
	localparam int DIG_W = 4 * NDIG;
	localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int BIN_W = STEPS * STEP_BITS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DIG_W-1:0] bcd_q;
	logic [BIN_W-1:0] bin_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIG_W-1:0] bcd_v;
	logic [BIN_W-1:0] bin_v;

	// double dabble unit: STEP_BITS rounds of add-3 correction then shift
	always_comb begin
		bcd_v = bcd_q;
		bin_v = bin_q;
		for (int b = 0; b < STEP_BITS; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_v[4*d +: 4] >= 4'd5)
					bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
			end
			bcd_v = {bcd_v[DIG_W-2:0], bin_v[BIN_W-1]};
			bin_v = {bin_v[BIN_W-2:0], 1'b0};
		end
	end

	// step counter and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= hex ? '0 : CNT_W'(STEPS);
			done_q <= hex;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// digit and shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			bcd_q <= hex ? DIG_W'(mag) : '0;
			bin_q <= BIN_W'(mag);
		end else if (cnt_q != '0) begin
			bcd_q <= bcd_v;
			bin_q <= bin_v;
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

	// a new start never lands while the unit is still stepping
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> !start)
		else $error("conv restarted mid conversion");

	// done rises in the cycle after the final step
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CNT_W'(1) && !start) |=> done)
		else $error("conv done missing after last step");

	// the lowest decimal digit left in the register is a valid BCD code
	a_bcd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cnt_q) == CNT_W'(1)) |-> (bcd_q[3:0] < DEC_RADIX))
		else $error("conv produced a non-decimal digit");

endmodule
